>>> hdl/hsvm_pkg.sv
// Shared types and constants for the RGB-to-HSV color mask.
`timescale 1ns / 1ps

package hsvm_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 9;

    localparam logic [CFG_AW-1:0] CFG_RED_HUE_HIGH  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_RED_WRAP_LOW  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RED_SAT_MIN   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_RED_VAL_MIN   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_BLUE_HUE_LOW  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_BLUE_HUE_HIGH = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_BLUE_SAT_MIN  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_BLUE_VAL_MIN  = 3'd7;

    localparam logic [HUE_W-1:0]  RST_RED_HUE_HIGH  = 9'd25;
    localparam logic [HUE_W-1:0]  RST_RED_WRAP_LOW  = 9'd340;
    localparam logic [CHAN_W-1:0] RST_RED_SAT_MIN   = 8'd70;
    localparam logic [CHAN_W-1:0] RST_RED_VAL_MIN   = 8'd60;
    localparam logic [HUE_W-1:0]  RST_BLUE_HUE_LOW  = 9'd200;
    localparam logic [HUE_W-1:0]  RST_BLUE_HUE_HIGH = 9'd280;
    localparam logic [CHAN_W-1:0] RST_BLUE_SAT_MIN  = 8'd127;
    localparam logic [CHAN_W-1:0] RST_BLUE_VAL_MIN  = 8'd0;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_red;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue_scaled;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
        logic              kept;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
    } result_t;

endpackage

>>> hdl/hsvm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module hsvm_div #(
    parameter int DW = 16,
    parameter int SW = 8,
    parameter int QW = 8
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    localparam int CW = (DW > SW + QW) ? DW : SW + QW;

    logic [DW-1:0] rem_reg [QW-1];
    logic [SW-1:0] dsr_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [SW-1:0] dsr_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] quo_next;
        logic [CW-1:0] shifted;
        logic [CW-1:0] diff;
        logic          take;

        if (i == 0) begin : g_first
            assign rem_in = dividend;
            assign dsr_in = divisor;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign dsr_in = dsr_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign shifted = CW'(dsr_in) << (QW - 1 - i);
        assign take    = CW'(rem_in) >= shifted;
        assign diff    = CW'(rem_in) - shifted;

        always_comb begin
            quo_next             = quo_in;
            quo_next[QW - 1 - i] = take;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[i] <= quo_next;
            end
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= take ? diff[DW-1:0] : rem_in;
                    dsr_reg[i] <= dsr_in;
                end
            end
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

>>> hdl/rgb_to_hsv_color_mask.sv
// Top level: BGR pixel to HSV with red/blue band color mask.
//
//  Channel | Ports                          | Beat
//  --------+--------------------------------+----------------------------------
//  input   | s_valid, s_ready, s_data       | one BGR pixel (pixel_t)
//  result  | m_valid, m_ready, m_data       | HSV, kept flag, masked pixel
//  config  | cfg_wr_en, cfg_addr, cfg_wdata | one threshold register write
//
// One pixel enters per cycle while the output is not stalled; a pixel passes three
// arithmetic stages, eight divider stages (one quotient bit each), and the output register.
// Reset clears all valid bits and loads the threshold defaults.
// A stalled output holds the whole pipeline; s_ready is low only then.
`timescale 1ns / 1ps

module rgb_to_hsv_color_mask (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  hsvm_pkg::pixel_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output hsvm_pkg::result_t              m_data,
    input  logic                           cfg_wr_en,
    input  logic [hsvm_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [hsvm_pkg::CFG_DW-1:0]    cfg_wdata
);

    import hsvm_pkg::*;

    localparam int QW      = CHAN_W;
    localparam int NUM_W   = 17;
    localparam int HDVD_W  = 25;
    localparam int HDSR_W  = 17;
    localparam int SDVD_W  = 16;
    localparam int SGN_W   = 19;

    typedef struct packed {
        pixel_t            pix;
        logic [CHAN_W-1:0] mx;
        logic              red_hue;
        logic              blue_hue;
    } side_t;

    logic [HUE_W-1:0]  red_hue_high_reg, red_wrap_low_reg, blue_hue_low_reg, blue_hue_high_reg;
    logic [CHAN_W-1:0] red_sat_min_reg, red_val_min_reg, blue_sat_min_reg, blue_val_min_reg;

    logic en;

    logic              v1_reg;
    pixel_t            pix1_reg;
    logic [CHAN_W-1:0] mx1_reg, c1_reg;
    max_sel_t          sel1_reg;

    logic              v2_reg;
    pixel_t            pix2_reg;
    logic [CHAN_W-1:0] mx2_reg, den2_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [SDVD_W-1:0] sdvd2_reg;

    logic              v3_reg;
    side_t             side3_reg;
    logic [HDVD_W-1:0] hdvd3_reg;
    logic [HDSR_W-1:0] hdsr3_reg;
    logic [SDVD_W-1:0] sdvd3_reg;

    logic              vd_reg   [QW];
    side_t             side_reg [QW];

    logic              m_valid_reg;
    result_t           m_data_reg;

    logic [CHAN_W-1:0] mx1_next, mn1_next;
    max_sel_t          sel1_next;

    logic signed [SGN_W-1:0] diff_s, num_s;
    logic [15:0]             base_x_c;
    logic [NUM_W-1:0]        num2_next;
    logic [CHAN_W-1:0]       den2_next;

    logic [HDSR_W-1:0] t_rhh, t_rwl, t_bhl, t_bhh;
    logic              red_hue3_next, blue_hue3_next;

    logic [QW-1:0]     hue_q, sat_q;
    side_t             side_last;
    logic [CHAN_W-1:0] sat_fin;
    logic              kept_fin;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_hue_high_reg  <= RST_RED_HUE_HIGH;
            red_wrap_low_reg  <= RST_RED_WRAP_LOW;
            red_sat_min_reg   <= RST_RED_SAT_MIN;
            red_val_min_reg   <= RST_RED_VAL_MIN;
            blue_hue_low_reg  <= RST_BLUE_HUE_LOW;
            blue_hue_high_reg <= RST_BLUE_HUE_HIGH;
            blue_sat_min_reg  <= RST_BLUE_SAT_MIN;
            blue_val_min_reg  <= RST_BLUE_VAL_MIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_RED_HUE_HIGH:  red_hue_high_reg  <= cfg_wdata;
                CFG_RED_WRAP_LOW:  red_wrap_low_reg  <= cfg_wdata;
                CFG_RED_SAT_MIN:   red_sat_min_reg   <= cfg_wdata[CHAN_W-1:0];
                CFG_RED_VAL_MIN:   red_val_min_reg   <= cfg_wdata[CHAN_W-1:0];
                CFG_BLUE_HUE_LOW:  blue_hue_low_reg  <= cfg_wdata;
                CFG_BLUE_HUE_HIGH: blue_hue_high_reg <= cfg_wdata;
                CFG_BLUE_SAT_MIN:  blue_sat_min_reg  <= cfg_wdata[CHAN_W-1:0];
                CFG_BLUE_VAL_MIN:  blue_val_min_reg  <= cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: max, min, dominant channel.
    always_comb begin
        if (s_data.in_blue >= s_data.in_green && s_data.in_blue >= s_data.in_red) begin
            sel1_next = MAX_BLUE;
            mx1_next  = s_data.in_blue;
        end else if (s_data.in_green >= s_data.in_red) begin
            sel1_next = MAX_GREEN;
            mx1_next  = s_data.in_green;
        end else begin
            sel1_next = MAX_RED;
            mx1_next  = s_data.in_red;
        end
        mn1_next = s_data.in_red;
        if (s_data.in_green < mn1_next) begin
            mn1_next = s_data.in_green;
        end
        if (s_data.in_blue < mn1_next) begin
            mn1_next = s_data.in_blue;
        end
    end

    // Stage 2: hue numerator in degrees over denominator c.
    always_comb begin
        unique case (sel1_reg)
            MAX_BLUE: begin
                diff_s   = SGN_W'($signed({1'b0, pix1_reg.in_red}))
                         - SGN_W'($signed({1'b0, pix1_reg.in_green}));
                base_x_c = 16'(c1_reg) * 16'd240;
            end
            MAX_GREEN: begin
                diff_s   = SGN_W'($signed({1'b0, pix1_reg.in_blue}))
                         - SGN_W'($signed({1'b0, pix1_reg.in_red}));
                base_x_c = 16'(c1_reg) * 16'd120;
            end
            default: begin
                diff_s   = SGN_W'($signed({1'b0, pix1_reg.in_green}))
                         - SGN_W'($signed({1'b0, pix1_reg.in_blue}));
                base_x_c = 16'd0;
            end
        endcase
        num_s = $signed({3'b000, base_x_c}) + diff_s * SGN_W'(60);
        if (num_s < 0) begin
            num_s = num_s + $signed({2'b00, 17'(17'(c1_reg) * 17'd360)});
        end
        if (c1_reg == '0) begin
            num2_next = '0;
            den2_next = CHAN_W'(1);
        end else begin
            num2_next = num_s[NUM_W-1:0];
            den2_next = c1_reg;
        end
    end

    // Stage 3: divider operands and exact hue band tests.
    always_comb begin
        t_rhh = HDSR_W'(red_hue_high_reg)  * HDSR_W'(den2_reg);
        t_rwl = HDSR_W'(red_wrap_low_reg)  * HDSR_W'(den2_reg);
        t_bhl = HDSR_W'(blue_hue_low_reg)  * HDSR_W'(den2_reg);
        t_bhh = HDSR_W'(blue_hue_high_reg) * HDSR_W'(den2_reg);
        red_hue3_next  = (num2_reg <= t_rhh) || (num2_reg >= t_rwl);
        blue_hue3_next = (num2_reg >= t_bhl) && (num2_reg <= t_bhh);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix1_reg  <= s_data;
            mx1_reg   <= mx1_next;
            c1_reg    <= mx1_next - mn1_next;
            sel1_reg  <= sel1_next;

            pix2_reg  <= pix1_reg;
            mx2_reg   <= mx1_reg;
            num2_reg  <= num2_next;
            den2_reg  <= den2_next;
            sdvd2_reg <= SDVD_W'(c1_reg) * SDVD_W'(255);

            side3_reg.pix      <= pix2_reg;
            side3_reg.mx       <= mx2_reg;
            side3_reg.red_hue  <= red_hue3_next;
            side3_reg.blue_hue <= blue_hue3_next;
            hdvd3_reg <= HDVD_W'(num2_reg) * HDVD_W'(255);
            hdsr3_reg <= HDSR_W'(den2_reg) * HDSR_W'(360);
            sdvd3_reg <= sdvd2_reg;

            side_reg[0] <= side3_reg;
            for (int i = 1; i < QW; i++) begin
                side_reg[i] <= side_reg[i-1];
            end

            m_data_reg.hue_scaled <= hue_q;
            m_data_reg.saturation <= sat_fin;
            m_data_reg.brightness <= side_last.mx;
            m_data_reg.kept       <= kept_fin;
            m_data_reg.out_blue   <= kept_fin ? side_last.pix.in_blue  : '0;
            m_data_reg.out_green  <= kept_fin ? side_last.pix.in_green : '0;
            m_data_reg.out_red    <= kept_fin ? side_last.pix.in_red   : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < QW; i++) begin
                vd_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < QW; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
            m_valid_reg <= vd_reg[QW-1];
        end
    end

    hsvm_div #(
        .DW (HDVD_W),
        .SW (HDSR_W),
        .QW (QW)
    ) u_hue_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (hdvd3_reg),
        .divisor  (hdsr3_reg),
        .quotient (hue_q)
    );

    hsvm_div #(
        .DW (SDVD_W),
        .SW (CHAN_W),
        .QW (QW)
    ) u_sat_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (sdvd3_reg),
        .divisor  (side3_reg.mx),
        .quotient (sat_q)
    );

    // Final stage: saturation of black is zero; combine band tests.
    always_comb begin
        side_last = side_reg[QW-1];
        sat_fin   = (side_last.mx == '0) ? '0 : sat_q;
        kept_fin  = (side_last.red_hue && sat_fin >= red_sat_min_reg
                     && side_last.mx >= red_val_min_reg)
                 || (side_last.blue_hue && sat_fin >= blue_sat_min_reg
                     && side_last.mx >= blue_val_min_reg);
    end

endmodule

>>> test/tb.sv
// Testbench for rgb_to_hsv_color_mask: random and directed pixels checked against an HSV mask predictor.
`timescale 1ns / 1ps

module tb;
    import hsvm_pkg::*;

    localparam int NUM_THRESH   = 8;
    localparam int PIPE_LATENCY = 12;
    localparam int LONG_HOLD    = 96;
    localparam int DRAIN_LIMIT  = 5000;

    typedef logic [CFG_DW-1:0] thresh_set_t [NUM_THRESH];
    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    class hsv_mask_scoreboard;
        result_t masked_pixels_q[$];
        logic [CFG_DW-1:0] thr [NUM_THRESH];
        int mismatches;

        function new();
            mismatches = 0;
            load_defaults();
        endfunction

        function void load_defaults();
            thr[CFG_RED_HUE_HIGH]  = RST_RED_HUE_HIGH;
            thr[CFG_RED_WRAP_LOW]  = RST_RED_WRAP_LOW;
            thr[CFG_RED_SAT_MIN]   = RST_RED_SAT_MIN;
            thr[CFG_RED_VAL_MIN]   = RST_RED_VAL_MIN;
            thr[CFG_BLUE_HUE_LOW]  = RST_BLUE_HUE_LOW;
            thr[CFG_BLUE_HUE_HIGH] = RST_BLUE_HUE_HIGH;
            thr[CFG_BLUE_SAT_MIN]  = RST_BLUE_SAT_MIN;
            thr[CFG_BLUE_VAL_MIN]  = RST_BLUE_VAL_MIN;
        endfunction

        function void set_threshold(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_RED_SAT_MIN, CFG_RED_VAL_MIN, CFG_BLUE_SAT_MIN, CFG_BLUE_VAL_MIN: begin
                    thr[idx] = {1'b0, val[CHAN_W-1:0]};
                end
                default: begin
                    thr[idx] = val;
                end
            endcase
        endfunction

        function result_t hsv_mask_of(pixel_t p);
            int b, g, r, mx, mn, c, sat, num, den;
            max_sel_t sel;
            bit red_ok, blue_ok;
            result_t res;
            b = p.in_blue;
            g = p.in_green;
            r = p.in_red;
            mx = r;
            sel = MAX_RED;
            if (g >= mx) begin
                mx = g;
                sel = MAX_GREEN;
            end
            if (b >= mx) begin
                mx = b;
                sel = MAX_BLUE;
            end
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            c = mx - mn;
            sat = (mx > 0) ? (255 * c) / mx : 0;
            if (c == 0) begin
                num = 0;
                den = 1;
            end else begin
                den = c;
                case (sel)
                    MAX_BLUE:  num = 240 * c + 60 * (r - g);
                    MAX_GREEN: num = 120 * c + 60 * (b - r);
                    default: begin
                        num = 60 * (g - b);
                        if (num < 0) num += 360 * c;
                    end
                endcase
            end
            red_ok = (num <= int'(thr[CFG_RED_HUE_HIGH]) * den
                      || num >= int'(thr[CFG_RED_WRAP_LOW]) * den)
                     && sat >= int'(thr[CFG_RED_SAT_MIN])
                     && mx >= int'(thr[CFG_RED_VAL_MIN]);
            blue_ok = num >= int'(thr[CFG_BLUE_HUE_LOW]) * den
                      && num <= int'(thr[CFG_BLUE_HUE_HIGH]) * den
                      && sat >= int'(thr[CFG_BLUE_SAT_MIN])
                      && mx >= int'(thr[CFG_BLUE_VAL_MIN]);
            res.hue_scaled = CHAN_W'((num * 255) / (360 * den));
            res.saturation = CHAN_W'(sat);
            res.brightness = CHAN_W'(mx);
            res.kept       = red_ok || blue_ok;
            res.out_blue   = res.kept ? p.in_blue  : '0;
            res.out_green  = res.kept ? p.in_green : '0;
            res.out_red    = res.kept ? p.in_red   : '0;
            return res;
        endfunction

        function int pending();
            return masked_pixels_q.size();
        endfunction

        function void note_pixel(pixel_t p);
            masked_pixels_q.push_back(hsv_mask_of(p));
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, int got, int want);
            if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (masked_pixels_q.size() == 0) begin
                report($sformatf("result beat with nothing pending: %h", got));
                return;
            end
            want = masked_pixels_q.pop_front();
            check_field("hue_scaled", got.hue_scaled, want.hue_scaled);
            check_field("saturation", got.saturation, want.saturation);
            check_field("brightness", got.brightness, want.brightness);
            check_field("kept",       got.kept,       want.kept);
            check_field("out_blue",   got.out_blue,   want.out_blue);
            check_field("out_green",  got.out_green,  want.out_green);
            check_field("out_red",    got.out_red,    want.out_red);
        endtask

        task flag_leftovers();
            if (masked_pixels_q.size() != 0)
                report($sformatf("%0d results never arrived", masked_pixels_q.size()));
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    pixel_t             s_data;
    logic               m_valid;
    logic               m_ready;
    result_t            m_data;
    logic               cfg_wr_en;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [CFG_DW-1:0]  cfg_wdata;

    hsv_mask_scoreboard sb;
    rx_mode_t           rx_mode = RX_ALWAYS;
    bit                 long_hold_req = 1'b0;
    int                 rx_tick = 0;

    rgb_to_hsv_color_mask DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_pixel(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                rx_tick++;
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(99) < 65);
                    default:   m_ready <= ((rx_tick % 7) < 4);
                endcase
            end
        end
    end

    initial begin
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pixel_t px(int b, int g, int r);
        pixel_t p;
        p.in_blue  = CHAN_W'(b);
        p.in_green = CHAN_W'(g);
        p.in_red   = CHAN_W'(r);
        return p;
    endfunction

    function automatic int rand_chan();
        int k;
        k = $urandom_range(15);
        if (k == 0) return 0;
        if (k == 1) return 255;
        return $urandom_range(255);
    endfunction

    function automatic pixel_t random_pixel();
        int a, z;
        a = rand_chan();
        z = rand_chan();
        case ($urandom_range(9))
            0: return px(a, a, a);
            1: return px(a, a, z);
            2: return px(z, a, a);
            3: return px(a, z, a);
            default: return px(rand_chan(), rand_chan(), rand_chan());
        endcase
    endfunction

    function automatic thresh_set_t make_thresholds(int rhh, int rwl, int rsm, int rvm,
                                                    int bhl, int bhh, int bsm, int bvm);
        thresh_set_t t;
        t[CFG_RED_HUE_HIGH]  = CFG_DW'(rhh);
        t[CFG_RED_WRAP_LOW]  = CFG_DW'(rwl);
        t[CFG_RED_SAT_MIN]   = CFG_DW'(rsm);
        t[CFG_RED_VAL_MIN]   = CFG_DW'(rvm);
        t[CFG_BLUE_HUE_LOW]  = CFG_DW'(bhl);
        t[CFG_BLUE_HUE_HIGH] = CFG_DW'(bhh);
        t[CFG_BLUE_SAT_MIN]  = CFG_DW'(bsm);
        t[CFG_BLUE_VAL_MIN]  = CFG_DW'(bvm);
        return t;
    endfunction

    function automatic int rand_hue();
        return ($urandom_range(7) == 0) ? $urandom_range(361, 511) : $urandom_range(360);
    endfunction

    task automatic send_pixel(pixel_t p);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle_idle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic program_thresholds(thresh_set_t vals);
        foreach (vals[i]) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_AW'(i);
            cfg_wdata <= vals[i];
            sb.set_threshold(CFG_AW'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drive_random(int count, bit gaps);
        int burst_left;
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < count; i++) begin
            if (gaps && i == count / 2) begin
                // hold until the pipeline is empty
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0) @(posedge aclk);
            end else if (gaps && burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
            send_pixel(random_pixel());
            burst_left--;
        end
    endtask

    task automatic run_phase(thresh_set_t vals, int count, rx_mode_t mode, bit gaps, bit hold);
        settle_idle();
        program_thresholds(vals);
        rx_mode = mode;
        if (hold) long_hold_req = 1'b1;
        drive_random(count, gaps);
    endtask

    initial begin
        pixel_t directed[$];
        thresh_set_t defaults;
        sb = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults straight out of reset
        rx_mode = RX_RANDOM;
        directed = '{px(0, 0, 0), px(255, 255, 255), px(128, 128, 128),
                     px(0, 0, 255), px(0, 255, 0), px(255, 0, 0),
                     px(200, 200, 50), px(50, 200, 200), px(200, 50, 200),
                     px(1, 0, 255), px(0, 100, 240), px(0, 101, 240),
                     px(85, 0, 255), px(86, 0, 255), px(255, 170, 0),
                     px(255, 171, 0), px(255, 0, 170), px(255, 0, 171),
                     px(255, 128, 128), px(255, 129, 129), px(0, 0, 60),
                     px(0, 0, 59), px(255, 0, 255)};
        foreach (directed[i]) send_pixel(directed[i]);
        drive_random(150, 1'b1);

        defaults = make_thresholds(RST_RED_HUE_HIGH, RST_RED_WRAP_LOW, RST_RED_SAT_MIN,
                                   RST_RED_VAL_MIN, RST_BLUE_HUE_LOW, RST_BLUE_HUE_HIGH,
                                   RST_BLUE_SAT_MIN, RST_BLUE_VAL_MIN);
        run_phase(make_thresholds(0, 0, 0, 0, 0, 0, 0, 0), 100, RX_ALWAYS, 1'b0, 1'b0);
        run_phase(make_thresholds(511, 511, 255, 255, 511, 511, 255, 255),
                  100, RX_PATTERN, 1'b1, 1'b0);
        run_phase(defaults, 150, RX_ALWAYS, 1'b0, 1'b1);
        run_phase(make_thresholds(0, 360, 0, 255, 0, 360, 255, 0),
                  110, RX_RANDOM, 1'b1, 1'b0);
        for (int k = 0; k < 3; k++) begin
            run_phase(make_thresholds(rand_hue(), rand_hue(), $urandom_range(200),
                                      $urandom_range(200), rand_hue(), rand_hue(),
                                      $urandom_range(200), $urandom_range(200)),
                      110, rx_mode_t'($urandom_range(2)), 1'b1, k == 1);
        end

        settle_idle();
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
